>>> src/murmur3_32bit_hash_macros.svh
// Assertion macros for the murmur3_32bit_hash checker.
`ifndef MURMUR3_32BIT_HASH_MACROS_SVH
`define MURMUR3_32BIT_HASH_MACROS_SVH

// Property checked at every clock edge outside reset.
`define M3H_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every clock edge, reset included.
`define M3H_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/m3h_pkg.sv
// Shared constants and types for the murmur3 hasher.
package m3h_pkg;

  localparam logic [31:0] C1     = 32'hcc9e2d51;
  localparam logic [31:0] C2     = 32'h1b873593;
  localparam logic [31:0] MIXADD = 32'he6546b64;
  localparam logic [31:0] F1     = 32'h85ebca6b;
  localparam logic [31:0] F2     = 32'hc2b2ae35;

  // how the back end folds a word into the hash
  localparam logic [1:0] MODE_FULL = 2'd0;  // xor, rotate, times 5 plus constant
  localparam logic [1:0] MODE_TAIL = 2'd1;  // xor only
  localparam logic [1:0] MODE_NONE = 2'd2;  // nothing to fold

  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [31:0] k;     // scrambled word
    logic [2:0]  len;   // bytes added to the length
    logic        last;
    logic [1:0]  mode;
  } entry_t;

endpackage

>>> src/murmur3_32bit_hash.sv
// Top level of the streaming murmur3 x86_32 hasher.
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_data_word, in_byte_count, in_last_word
//  out      output     out_valid/out_stall  out_hash_value
//  cfg      input      cfg_wr_en            cfg_wr_data (seed)
//
// A word is taken every cycle while the 4-entry queue has room; a non-last
// word is folded by the h recurrence alone, a last word by a fold plus
// three fmix32 steps. Reset is synchronous and clears the queue and seed.
// in_stall rises only when the queue is full; out_stall holds the result
// register while the back end keeps folding later words.
module murmur3_32bit_hash
  import m3h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0] seed_r, seed_nxt;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_valid;
  entry_t      push_entry;
  entry_t      pop_entry;

  assign seed_nxt = cfg_wr_en ? cfg_wr_data : seed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else begin
      seed_r <= seed_nxt;
    end
  end

  m3h_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_byte_count (in_byte_count),
    .in_last_word  (in_last_word),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  m3h_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_valid),
    .full       (q_full)
  );

  m3h_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .seed           (seed_r),
    .q_valid        (q_valid),
    .q_entry        (pop_entry),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hash_value (out_hash_value)
  );

endmodule

>>> src/m3h_front.sv
// Front end: classifies input words, masks tails and scrambles k.
module m3h_front
  import m3h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last_word,
  input  logic        q_full,
  output logic        q_push,
  output entry_t      q_entry
);

  logic        adv;
  logic        in_acc;
  logic [2:0]  cnt_sat;
  logic [31:0] mask;
  logic [31:0] word_m;
  logic [2:0]  len_c;
  logic [1:0]  mode_c;

  logic        a_valid_r, a_valid_nxt;
  logic [31:0] a_word_r;
  logic [2:0]  a_len_r;
  logic        a_last_r;
  logic [1:0]  a_mode_r;

  logic        b_valid_r, b_valid_nxt;
  logic [31:0] b_k1_r;
  logic [2:0]  b_len_r;
  logic        b_last_r;
  logic [1:0]  b_mode_r;

  logic [31:0] k_rot;

  // whole pipeline freezes while the queue is full
  assign adv      = !q_full;
  assign in_stall = q_full;
  assign in_acc   = in_valid && adv;

  always_comb begin
    cnt_sat = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    unique case (cnt_sat)
      3'd1:    mask = 32'h0000_00ff;
      3'd2:    mask = 32'h0000_ffff;
      3'd3:    mask = 32'h00ff_ffff;
      default: mask = 32'hffff_ffff;
    endcase
    if (!in_last_word) begin
      len_c  = 3'd4;
      mode_c = MODE_FULL;
      word_m = in_data_word;
    end else begin
      len_c  = cnt_sat;
      word_m = in_data_word & mask;
      if (cnt_sat == 3'd4) begin
        mode_c = MODE_FULL;
      end else if (cnt_sat == 3'd0) begin
        mode_c = MODE_NONE;
      end else begin
        mode_c = MODE_TAIL;
      end
    end
  end

  assign a_valid_nxt = adv ? in_acc : a_valid_r;
  assign b_valid_nxt = adv ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_word_r <= word_m;
      a_len_r  <= len_c;
      a_last_r <= in_last_word;
      a_mode_r <= mode_c;
      b_k1_r   <= a_word_r * C1;
      b_len_r  <= a_len_r;
      b_last_r <= a_last_r;
      b_mode_r <= a_mode_r;
    end
  end

  assign k_rot = {b_k1_r[16:0], b_k1_r[31:17]};

  assign q_push       = adv && b_valid_r;
  assign q_entry.k    = k_rot * C2;
  assign q_entry.len  = b_len_r;
  assign q_entry.last = b_last_r;
  assign q_entry.mode = b_mode_r;

endmodule

>>> src/m3h_queue.sv
// Short FIFO of scrambled words between front and back ends.
module m3h_queue
  import m3h_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t pop_entry,
  output logic   not_empty,
  output logic   full
);

  entry_t mem [Q_DEPTH];

  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  assign wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
  assign rd_ptr_nxt = do_pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = QCNT_W'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = QCNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  assign pop_entry = mem[rd_ptr_r];

endmodule

>>> src/m3h_back.sv
// Back end: hash recurrence, length count, fmix32 and result register.
module m3h_back
  import m3h_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] seed,
  input  logic        q_valid,
  input  entry_t      q_entry,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_hash_value
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FM1  = 2'd1;
  localparam logic [1:0] ST_FM2  = 2'd2;
  localparam logic [1:0] ST_FM3  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic        start_r, start_nxt;
  logic [31:0] h_r, h_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] t_r, t_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_hash_r, out_hash_nxt;

  logic [31:0] h_base;
  logic [31:0] len_base;
  logic [31:0] len_sum;
  logic [31:0] hx;
  logic [31:0] hrot;
  logic [31:0] h_mix;
  logic [31:0] h_fold;
  logic        out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;

  always_comb begin
    h_base   = start_r ? seed : h_r;
    len_base = start_r ? 32'd0 : len_r;
    len_sum  = len_base + {29'd0, q_entry.len};
    hx       = h_base ^ q_entry.k;
    hrot     = {hx[18:0], hx[31:19]};
    h_mix    = hrot + {hrot[29:0], 2'b00} + MIXADD;
    unique case (q_entry.mode)
      MODE_FULL: h_fold = h_mix;
      MODE_TAIL: h_fold = hx;
      default:   h_fold = h_base;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r;
    h_nxt         = h_r;
    len_nxt       = len_r;
    t_nxt         = t_r;
    out_hash_nxt  = out_hash_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_entry.last) begin
            t_nxt     = h_fold ^ len_sum;
            state_nxt = ST_FM1;
          end else begin
            h_nxt     = h_mix;
            len_nxt   = len_sum;
            start_nxt = 1'b0;
          end
        end
      end
      ST_FM1: begin
        t_nxt     = (t_r ^ {16'd0, t_r[31:16]}) * F1;
        state_nxt = ST_FM2;
      end
      ST_FM2: begin
        t_nxt     = (t_r ^ {13'd0, t_r[31:13]}) * F2;
        state_nxt = ST_FM3;
      end
      default: begin
        // hold here while an earlier hash still waits at the output
        if (out_free) begin
          out_hash_nxt  = t_r ^ {16'd0, t_r[31:16]};
          out_valid_nxt = 1'b1;
          start_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      start_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r        <= h_nxt;
    len_r      <= len_nxt;
    t_r        <= t_nxt;
    out_hash_r <= out_hash_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hash_value = out_hash_r;

endmodule

>>> src/m3h_checker.sv
// Port-level assertions for the murmur3 hasher, bound to the top level.
`include "murmur3_32bit_hash_macros.svh"

module m3h_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_hash_value
);

  `M3H_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped under stall")
  `M3H_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_hash_value), "stalled hash changed")
  // the queue is empty after reset, so input is never stalled then
  `M3H_ASSERT_ALWAYS(a_rst_no_stall, !rst_n |=> !in_stall, "input stalled right after reset")
  // a hash must pass the front stages, the queue and fmix32 after reset
  `M3H_ASSERT_ALWAYS(a_rst_latency, !rst_n |=> !out_valid [*3], "result too early after reset")

endmodule

bind murmur3_32bit_hash m3h_checker u_m3h_checker (.*);
